// ===== design/pie_pkg.sv =====
// ----------------------------------------------------------------------------
// pie_pkg
// shared types, register indexes and fixed-point constants of the pie drop
// controller
// ----------------------------------------------------------------------------
package pie_pkg;

  localparam int PROB_W  = 31;
  localparam int DELAY_W = 24;
  localparam int ACC_W   = 35;
  localparam int FIX_W   = 13;

  // item kinds
  localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
  localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
  localparam logic [1:0] FUNC_UPDATE  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DELAY_SETPOINT   = 3'd0;
  localparam logic [2:0] CFG_UPDATE_INTERVAL  = 3'd1;
  localparam logic [2:0] CFG_ALPHA_GAIN       = 3'd2;
  localparam logic [2:0] CFG_BETA_GAIN        = 3'd3;
  localparam logic [2:0] CFG_MEAN_PACKET_SIZE = 3'd4;
  localparam logic [2:0] CFG_BURST_REFILL     = 3'd5;

  // register reset values
  localparam logic [23:0] RST_DELAY_SETPOINT   = 24'd15000;
  localparam logic [23:0] RST_UPDATE_INTERVAL  = 24'd15000;
  localparam logic [15:0] RST_ALPHA_GAIN       = 16'd1024;
  localparam logic [15:0] RST_BETA_GAIN        = 16'd10240;
  localparam logic [14:0] RST_MEAN_PACKET_SIZE = 15'd2;
  localparam logic [23:0] RST_BURST_REFILL     = 24'd150000;

  localparam longint unsigned PIE_MAX_L = (64'd1 << PROB_W) - 64'd1;

  localparam logic [PROB_W-1:0] PIE_MAX   = PROB_W'(PIE_MAX_L);
  localparam logic [PROB_W-1:0] P_DIV5    = PROB_W'(PIE_MAX_L / 5);
  localparam logic [PROB_W-1:0] P_DIV10   = PROB_W'(PIE_MAX_L / 10);
  localparam logic [PROB_W-1:0] P_DIV50   = PROB_W'(PIE_MAX_L / 50);
  localparam logic [PROB_W-1:0] P_DIV1E2  = PROB_W'(PIE_MAX_L / 100);
  localparam logic [PROB_W-1:0] P_DIV1E3  = PROB_W'(PIE_MAX_L / 1000);
  localparam logic [PROB_W-1:0] P_DIV1E4  = PROB_W'(PIE_MAX_L / 10000);
  localparam logic [PROB_W-1:0] P_DIV1E5  = PROB_W'(PIE_MAX_L / 100000);
  localparam logic [PROB_W-1:0] P_DIV1E6  = PROB_W'(PIE_MAX_L / 1000000);

  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_LO  = ACC_W'(PIE_MAX_L * 17 / 20);
  localparam logic [ACC_W-1:0] ACC_HI  = ACC_W'(PIE_MAX_L * 17 / 2);

  // probability units per microsecond, 12 fractional bits
  localparam logic [23:0] SCALE_K = 24'((PIE_MAX_L << 12) / 1000000);

  localparam logic [5:0] SH_BASE = 6'(FIX_W + 12);

  typedef struct packed {
    logic [23:0] delay_setpoint;
    logic [23:0] update_interval;
    logic [15:0] alpha_gain;
    logic [15:0] beta_gain;
    logic [14:0] mean_packet_size;
    logic [23:0] burst_refill;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_EXEC,
    OP_MUL_ALPHA,
    OP_MUL_BETA,
    OP_SUM,
    OP_MAG,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_COMBINE,
    OP_SHIFT,
    OP_NEWP,
    OP_FINISH,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
  } dp_stat_t;

endpackage

// ===== design/pie_aqm_drop_controller.sv =====
// ----------------------------------------------------------------------------
// pie_aqm_drop_controller
// pie active queue management drop controller: enqueue decisions, delay
// reports and periodic probability updates
// ----------------------------------------------------------------------------
// steps: enqueue and dequeue items are captured, executed and loaded out;
//   update ticks run the staged update (multiplier shared over four products)
// flow: one item at a time; the output register holds a result while the
//   next item runs, so a stalled output costs nothing until the next result
// reset: synchronous active-low rst_n; registers load their defaults,
//   probability, delays and accumulation clear, burst allowance gets 150000
module pie_aqm_drop_controller import pie_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_queue_length,
  input  logic               in_queue_full,
  input  logic [PROB_W-1:0]  in_random_value,
  input  logic [DELAY_W-1:0] in_queue_delay,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_drop,
  output logic [PROB_W-1:0]  out_drop_probability,
  output logic [DELAY_W-1:0] out_burst_left,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  pie_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pie_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_func              (in_func),
    .in_queue_length      (in_queue_length),
    .in_queue_full        (in_queue_full),
    .in_random_value      (in_random_value),
    .in_queue_delay       (in_queue_delay),
    .out_drop             (out_drop),
    .out_drop_probability (out_drop_probability),
    .out_burst_left       (out_burst_left)
  );

endmodule

// ===== design/pie_cfg.sv =====
// ----------------------------------------------------------------------------
// pie_cfg
// configuration register file, written through its own valid/ready channel
// ----------------------------------------------------------------------------
module pie_cfg import pie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DELAY_SETPOINT:   cfg_nxt.delay_setpoint   = cfg_data;
        CFG_UPDATE_INTERVAL:  cfg_nxt.update_interval  = cfg_data;
        CFG_ALPHA_GAIN:       cfg_nxt.alpha_gain       = cfg_data[15:0];
        CFG_BETA_GAIN:        cfg_nxt.beta_gain        = cfg_data[15:0];
        CFG_MEAN_PACKET_SIZE: cfg_nxt.mean_packet_size = cfg_data[14:0];
        CFG_BURST_REFILL:     cfg_nxt.burst_refill     = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_setpoint   <= RST_DELAY_SETPOINT;
      cfg_r.update_interval  <= RST_UPDATE_INTERVAL;
      cfg_r.alpha_gain       <= RST_ALPHA_GAIN;
      cfg_r.beta_gain        <= RST_BETA_GAIN;
      cfg_r.mean_packet_size <= RST_MEAN_PACKET_SIZE;
      cfg_r.burst_refill     <= RST_BURST_REFILL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/pie_ctrl.sv =====
// ----------------------------------------------------------------------------
// pie_ctrl
// sequencer: takes one item, steps the datapath through it and hands the
// result to the output register
// ----------------------------------------------------------------------------
module pie_ctrl import pie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMB,
    ST_SHIFT,
    ST_NEWP,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.func == FUNC_UPDATE) begin
          state_nxt = ST_MUL_A;
        end else begin
          cmd.op    = OP_EXEC;
          state_nxt = ST_DONE;
        end
      end
      ST_MUL_A: begin
        cmd.op    = OP_MUL_ALPHA;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op    = OP_MUL_BETA;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.op    = OP_MUL_LO;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.op    = OP_MUL_HI;
        state_nxt = ST_COMB;
      end
      ST_COMB: begin
        cmd.op    = OP_COMBINE;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.op    = OP_SHIFT;
        state_nxt = ST_NEWP;
      end
      ST_NEWP: begin
        cmd.op    = OP_NEWP;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op    = OP_FINISH;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice without finishing");

  a_hold_pending_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE && out_valid_r))
    else $error("result overwritten before it was taken");

  a_fin_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (state_r == ST_DONE))
    else $error("update did not reach result stage");

endmodule

// ===== design/pie_dp.sv =====
// ----------------------------------------------------------------------------
// pie_dp
// datapath: controller state, enqueue decision, shared multiplier and the
// staged probability update
// ----------------------------------------------------------------------------
module pie_dp import pie_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_queue_length,
  input  logic               in_queue_full,
  input  logic [PROB_W-1:0]  in_random_value,
  input  logic [DELAY_W-1:0] in_queue_delay,
  output logic               out_drop,
  output logic [PROB_W-1:0]  out_drop_probability,
  output logic [DELAY_W-1:0] out_burst_left
);

  // persistent state
  logic [PROB_W-1:0]  prob_r, prob_nxt;
  logic [DELAY_W-1:0] burst_r, burst_nxt;
  logic [DELAY_W-1:0] prev_r, prev_nxt;
  logic [DELAY_W-1:0] cur_r, cur_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;

  // captured item
  logic [1:0]         func_r;
  logic [15:0]        qlen_r;
  logic               full_r;
  logic [PROB_W-1:0]  rnd_r;
  logic [DELAY_W-1:0] qdelay_r;

  // update working registers
  logic signed [51:0] prod_r;
  logic signed [42:0] e_r;
  logic               neg_r;
  logic [41:0]        mag_r;
  logic [5:0]         sh_r;
  logic [44:0]        lo_r;
  logic [65:0]        full_prod_r;
  logic [40:0]        p_r;
  logic [41:0]        np_r;
  logic               drop_r, drop_nxt;

  logic               out_drop_r;
  logic [PROB_W-1:0]  out_prob_r;
  logic [DELAY_W-1:0] out_burst_r;

  assign stat.func            = func_r;
  assign out_drop             = out_drop_r;
  assign out_drop_probability = out_prob_r;
  assign out_burst_left       = out_burst_r;

  // shared multiplier
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] mul_p;
  logic signed [24:0] err, trend;

  assign err   = $signed({1'b0, cur_r}) - $signed({1'b0, cfg.delay_setpoint});
  assign trend = $signed({1'b0, cur_r}) - $signed({1'b0, prev_r});

  always_comb begin
    case (cmd.op)
      OP_MUL_ALPHA: begin
        mul_a = $signed({10'b0, cfg.alpha_gain});
        mul_b = {err[24], err};
      end
      OP_MUL_BETA: begin
        mul_a = $signed({10'b0, cfg.beta_gain});
        mul_b = {trend[24], trend};
      end
      OP_MUL_LO: begin
        mul_a = $signed({5'b0, mag_r[20:0]});
        mul_b = $signed({2'b0, SCALE_K});
      end
      OP_MUL_HI: begin
        mul_a = $signed({5'b0, mag_r[41:21]});
        mul_b = $signed({2'b0, SCALE_K});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // auto-tuned shift from the present probability
  logic [5:0] sh_sel;
  always_comb begin
    if (prob_r < P_DIV1E6)      sh_sel = SH_BASE + 6'd11;
    else if (prob_r < P_DIV1E5) sh_sel = SH_BASE + 6'd9;
    else if (prob_r < P_DIV1E4) sh_sel = SH_BASE + 6'd7;
    else if (prob_r < P_DIV1E3) sh_sel = SH_BASE + 6'd5;
    else if (prob_r < P_DIV1E2) sh_sel = SH_BASE + 6'd3;
    else if (prob_r < P_DIV10)  sh_sel = SH_BASE + 6'd1;
    else                        sh_sel = SH_BASE;
  end

  logic signed [42:0] e_neg;
  logic [65:0]        shifted;
  logic [40:0]        p_cap;
  logic [41:0]        np_calc;
  logic [41:0]        np_dec;

  assign e_neg   = -e_r;
  assign shifted = full_prod_r >> sh_r;

  always_comb begin
    if (neg_r) begin
      np_calc = ({11'b0, prob_r} >= {1'b0, p_r}) ? ({11'b0, prob_r} - {1'b0, p_r}) : '0;
      p_cap   = p_r;
    end else begin
      // cap the step once probability is already high
      p_cap   = (prob_r >= P_DIV10 && p_r > {10'b0, P_DIV50}) ? {10'b0, P_DIV50} : p_r;
      np_calc = {11'b0, prob_r} + {1'b0, p_cap};
    end
  end

  // decay while the queue stays empty
  assign np_dec = (cur_r == '0 && prev_r == '0) ? (np_r - (np_r >> 6)) : np_r;

  // enqueue decision
  logic [DELAY_W-1:0] half_t;
  logic               no_early;
  logic [ACC_W-1:0]   acc_base;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [PROB_W-1:0]  rnd_mod;
  logic               early;

  assign half_t   = cfg.delay_setpoint >> 1;
  assign no_early = (prev_r < half_t && prob_r < P_DIV5) ||
                    ({1'b0, qlen_r} <= {1'b0, cfg.mean_packet_size, 1'b0});
  assign acc_base = (prob_r == '0) ? '0 : acc_r;
  assign acc_sum  = {1'b0, acc_base} + {5'b0, prob_r};
  assign acc_sat  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign rnd_mod  = (rnd_r == PIE_MAX) ? '0 : rnd_r;

  always_comb begin
    prob_nxt  = prob_r;
    burst_nxt = burst_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    acc_nxt   = acc_r;
    drop_nxt  = drop_r;
    early     = 1'b0;
    case (cmd.op)
      OP_CAPTURE: begin
        drop_nxt = 1'b0;
      end
      OP_EXEC: begin
        if (func_r == FUNC_ENQUEUE) begin
          if (full_r) begin
            acc_nxt  = '0;
            drop_nxt = 1'b1;
          end else begin
            if (burst_r == '0 && !no_early) begin
              acc_nxt = acc_sat;
              if (acc_sat < ACC_LO) begin
                early = 1'b0;
              end else if (acc_sat >= ACC_HI) begin
                early = 1'b1;
              end else if (rnd_mod < prob_r) begin
                acc_nxt = '0;
                early   = 1'b1;
              end
            end
            if (early) begin
              drop_nxt = 1'b1;
            end else if (prob_r == '0 && cur_r < half_t && prev_r < half_t) begin
              burst_nxt = cfg.burst_refill;
            end
          end
        end else if (func_r == FUNC_DEQUEUE) begin
          cur_nxt = qdelay_r;
        end
      end
      OP_FINISH: begin
        prob_nxt  = (np_dec > {11'b0, PIE_MAX}) ? PIE_MAX : np_dec[PROB_W-1:0];
        prev_nxt  = cur_r;
        burst_nxt = (burst_r < cfg.update_interval) ? '0 : (burst_r - cfg.update_interval);
      end
      default: begin
        prob_nxt = prob_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_r  <= '0;
      burst_r <= RST_BURST_REFILL;
      prev_r  <= '0;
      cur_r   <= '0;
      acc_r   <= '0;
    end else begin
      prob_r  <= prob_nxt;
      burst_r <= burst_nxt;
      prev_r  <= prev_nxt;
      cur_r   <= cur_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_r <= drop_nxt;
    case (cmd.op)
      OP_CAPTURE: begin
        func_r   <= in_func;
        qlen_r   <= in_queue_length;
        full_r   <= in_queue_full;
        rnd_r    <= in_random_value;
        qdelay_r <= in_queue_delay;
      end
      OP_MUL_ALPHA: begin
        prod_r <= mul_p;
      end
      OP_MUL_BETA: begin
        e_r    <= prod_r[42:0];
        prod_r <= mul_p;
      end
      OP_SUM: begin
        e_r <= e_r + $signed(prod_r[42:0]);
      end
      OP_MAG: begin
        neg_r <= e_r[42];
        mag_r <= e_r[42] ? e_neg[41:0] : e_r[41:0];
        sh_r  <= sh_sel;
      end
      OP_MUL_LO: begin
        prod_r <= mul_p;
      end
      OP_MUL_HI: begin
        lo_r   <= prod_r[44:0];
        prod_r <= mul_p;
      end
      OP_COMBINE: begin
        full_prod_r <= {prod_r[44:0], 21'b0} + {21'b0, lo_r};
      end
      OP_SHIFT: begin
        p_r <= shifted[40:0];
      end
      OP_NEWP: begin
        np_r <= np_calc;
      end
      OP_LOAD_OUT: begin
        out_drop_r  <= drop_r;
        out_prob_r  <= prob_r;
        out_burst_r <= burst_r;
      end
      default: begin
        p_r <= p_r;
      end
    endcase
  end

  a_finish_moves_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |=> (prev_r == $past(cur_r)))
    else $error("previous delay not taken from current delay");

  a_finish_ages_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |=> (burst_r <= $past(burst_r)))
    else $error("burst allowance grew on update");

  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EXEC && func_r == FUNC_ENQUEUE && full_r) |=> (drop_r && acc_r == '0))
    else $error("full queue did not drop and clear accumulation");

endmodule
